FILE: sv/gcc_pkg.sv
// gcc_pkg: shared constants and controller/datapath interface types
// for the graph component counter; no dependencies
package gcc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int NCNT_W       = $clog2(MAX_VERTICES + 1);
  localparam int VCFG_W       = 7;
  localparam int COMP_W       = 7;
  localparam int TALLY_W      = 12;

  localparam logic [VCFG_W-1:0]  VCOUNT_RESET = VCFG_W'(MAX_VERTICES);
  localparam logic [TALLY_W-1:0] TALLY_MAX    = '1;
  localparam logic [COMP_W-1:0]  COMP_MAX     = '1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_COUNT  = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic rd_ins;    // latch endpoints, read row a
    logic wr_a;      // set bit b in row a, bump tally
    logic wr_b;      // set bit a in row b
    logic cnt_init;  // clear visited, pending and component count
    logic seed;      // mark lowest unvisited vertex, start a component
    logic exp_rd;    // take one pending vertex, read its row
    logic exp_mg;    // merge unvisited neighbors into visited and pending
    logic finish;    // emit result, drop the graph
  } gcc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic edge_new;     // latched edge is in range and not yet stored
    logic cand_any;     // some vertex in range is still unvisited
    logic pending_any;  // some visited vertex still waits for expansion
  } gcc_sts_t;

endpackage

FILE: sv/gcc_ctrl.sv
// gcc_ctrl: sequencing state machine of the graph component counter
// depends on gcc_pkg for the command and status types
module gcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_opcode,
  input  gcc_pkg::gcc_sts_t sts,
  output gcc_pkg::gcc_cmd_t cmd,
  output logic              busy
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_INS_CK = 6'b000010,
    ST_INS_B  = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_EXP_RD = 6'b010000,
    ST_EXP_MG = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_opcode == gcc_pkg::OP_INSERT) begin
            cmd.rd_ins = 1'b1;
            state_nxt  = ST_INS_CK;
          end else begin
            cmd.cnt_init = 1'b1;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_INS_CK: begin
        if (sts.edge_new) begin
          cmd.wr_a  = 1'b1;
          state_nxt = ST_INS_B;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_INS_B: begin
        cmd.wr_b  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts.cand_any) begin
          cmd.seed  = 1'b1;
          state_nxt = ST_EXP_RD;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_EXP_RD: begin
        if (sts.pending_any) begin
          cmd.exp_rd = 1'b1;
          state_nxt  = ST_EXP_MG;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_EXP_MG: begin
        cmd.exp_mg = 1'b1;
        state_nxt  = ST_EXP_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: sv/gcc_dp.sv
// gcc_dp: adjacency row memory, visited/pending masks, tallies and result
// registers of the graph component counter; depends on gcc_pkg
module gcc_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gcc_pkg::gcc_cmd_t                cmd,
  output gcc_pkg::gcc_sts_t                sts,
  input  logic [gcc_pkg::VIDX_W-1:0]       in_vertex_a,
  input  logic [gcc_pkg::VIDX_W-1:0]       in_vertex_b,
  input  logic                             cfg_we,
  input  logic [gcc_pkg::VCFG_W-1:0]       cfg_vertex_count,
  output logic                             out_valid,
  output logic [gcc_pkg::COMP_W-1:0]       out_component_count,
  output logic [gcc_pkg::TALLY_W-1:0]      out_distinct_edges
);

  localparam int NV = gcc_pkg::MAX_VERTICES;

  // lowest-set-bit index of a one-hot word
  function automatic logic [gcc_pkg::VIDX_W-1:0] enc(input logic [NV-1:0] oh);
    logic [gcc_pkg::VIDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < NV; i++) begin
      if (oh[i]) r = r | gcc_pkg::VIDX_W'(i);
    end
    return r;
  endfunction

  logic [NV-1:0]                  adj_mem [NV];
  logic [NV-1:0]                  row_valid_r;
  logic [NV-1:0]                  rd_row_r;
  logic                           rd_ok_r;
  logic [NV-1:0]                  visited_r;
  logic [NV-1:0]                  pending_r;
  logic [gcc_pkg::VIDX_W-1:0]     a_r;
  logic [gcc_pkg::VIDX_W-1:0]     b_r;
  logic [gcc_pkg::VCFG_W-1:0]     vcount_r;
  logic [gcc_pkg::TALLY_W-1:0]    tally_r;
  logic [gcc_pkg::COMP_W-1:0]     comps_r;
  logic                           out_valid_r;
  logic [gcc_pkg::COMP_W-1:0]     out_comp_r;
  logic [gcc_pkg::TALLY_W-1:0]    out_edges_r;

  logic [gcc_pkg::NCNT_W-1:0]     eff_n;
  logic [NV-1:0]                  range_mask;
  logic [NV-1:0]                  cand;
  logic [NV-1:0]                  cand_1h;
  logic [NV-1:0]                  pend_1h;
  logic [NV-1:0]                  row_data;
  logic [NV-1:0]                  nbr_new;
  logic                           in_range;
  logic                           mem_we;
  logic [gcc_pkg::VIDX_W-1:0]     waddr;
  logic [gcc_pkg::VIDX_W-1:0]     wbit;
  logic [gcc_pkg::VIDX_W-1:0]     raddr;

  // effective vertex count saturates at the matrix size
  assign eff_n = (vcount_r > gcc_pkg::VCFG_W'(NV)) ? gcc_pkg::NCNT_W'(NV)
                                                   : gcc_pkg::NCNT_W'(vcount_r);

  always_comb begin
    for (int t = 0; t < NV; t++) begin
      range_mask[t] = (gcc_pkg::NCNT_W'(t) < eff_n);
    end
  end

  assign cand     = ~visited_r & range_mask;
  assign cand_1h  = cand & (~cand + NV'(1));
  assign pend_1h  = pending_r & (~pending_r + NV'(1));
  assign row_data = rd_ok_r ? rd_row_r : '0;
  assign nbr_new  = row_data & range_mask & ~visited_r;

  assign in_range = (gcc_pkg::NCNT_W'(a_r) < eff_n) && (gcc_pkg::NCNT_W'(b_r) < eff_n);

  assign sts.edge_new    = in_range && !row_data[b_r];
  assign sts.cand_any    = |cand;
  assign sts.pending_any = |pending_r;

  assign mem_we = cmd.wr_a | cmd.wr_b;
  assign waddr  = cmd.wr_a ? a_r : b_r;
  assign wbit   = cmd.wr_a ? b_r : a_r;
  assign raddr  = cmd.rd_ins ? in_vertex_a : enc(pend_1h);

  // adjacency rows: bit-enable write, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      if (row_valid_r[waddr]) begin
        adj_mem[waddr][wbit] <= 1'b1;
      end else begin
        adj_mem[waddr] <= NV'(1) << wbit;
      end
    end
    rd_row_r <= adj_mem[raddr];
    rd_ok_r  <= row_valid_r[raddr];
  end

  // an invalid row reads as all zeros
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (cmd.finish) begin
      row_valid_r <= '0;
    end else if (mem_we) begin
      row_valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_ins) begin
      a_r <= in_vertex_a;
      b_r <= in_vertex_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= gcc_pkg::VCOUNT_RESET;
      tally_r     <= '0;
      comps_r     <= '0;
      visited_r   <= '0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cfg_we) vcount_r <= cfg_vertex_count;
      if (cmd.wr_a && tally_r != gcc_pkg::TALLY_MAX) tally_r <= tally_r + 1'b1;
      if (cmd.cnt_init) begin
        visited_r <= '0;
        pending_r <= '0;
        comps_r   <= '0;
      end
      if (cmd.seed) begin
        visited_r <= visited_r | cand_1h;
        pending_r <= cand_1h;
        if (comps_r != gcc_pkg::COMP_MAX) comps_r <= comps_r + 1'b1;
      end
      if (cmd.exp_rd) pending_r <= pending_r & ~pend_1h;
      if (cmd.exp_mg) begin
        visited_r <= visited_r | nbr_new;
        pending_r <= pending_r | nbr_new;
      end
      if (cmd.finish) tally_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_comp_r  <= comps_r;
      out_edges_r <= tally_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_component_count = out_comp_r;
  assign out_distinct_edges  = out_edges_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_pending_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r & ~visited_r) == '0)
    else $error("pending vertex not marked visited");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_a |-> in_range)
    else $error("edge write with endpoint out of range");

  a_graph_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (row_valid_r == '0 && tally_r == '0))
    else $error("graph not cleared with the result");

endmodule

FILE: sv/graph_component_counter.sv
// graph_component_counter: top level, joins the controller and the datapath
// depends on gcc_pkg, gcc_ctrl and gcc_dp
//
// Builds an undirected graph of up to 64 vertices in an adjacency bit matrix
// and counts its connected components. An item is taken when start is high
// and busy is low. An insert item (opcode 0) stores edge (vertex_a, vertex_b)
// unless an endpoint is not below the configured vertex count; it produces no
// result and keeps busy high for a check step, plus a second write step when
// the edge is new (the matrix has one write port, so the two mirrored bits are
// written in turn). A count item (opcode 1) walks the graph row by row: a scan
// step opens each component, each vertex reached gets an adjacency row read
// and a merge of its neighbors, a read step that finds nothing pending closes
// each component, and a last scan step that finds no vertex left ends the
// walk. The result then shows on out_component_count and out_distinct_edges
// for exactly one cycle with out_valid high, the first cycle with busy low;
// the receiver cannot stall it, and the next item may be taken in that same
// cycle. The count also clears the matrix and the edge tally at once. There
// is no clearing pass after reset. cfg_vertex_count is written when cfg_we is
// high; the user must write it only while the block is idle, as the block
// does not enforce this itself; values above 64 act as 64.
module graph_component_counter (
  input  logic                          clk,
  input  logic                          rst_n,
  // item channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_opcode,
  input  logic [gcc_pkg::VIDX_W-1:0]    in_vertex_a,
  input  logic [gcc_pkg::VIDX_W-1:0]    in_vertex_b,
  // result channel
  output logic                          out_valid,
  output logic [gcc_pkg::COMP_W-1:0]    out_component_count,
  output logic [gcc_pkg::TALLY_W-1:0]   out_distinct_edges,
  // configuration
  input  logic                          cfg_we,
  input  logic [gcc_pkg::VCFG_W-1:0]    cfg_vertex_count
);

  gcc_pkg::gcc_cmd_t cmd;
  gcc_pkg::gcc_sts_t sts;

  // sequencer: insert check/write steps and the component walk
  gcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // matrix rows, walk masks, tallies and the result registers
  gcc_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_vertex_a         (in_vertex_a),
    .in_vertex_b         (in_vertex_b),
    .cfg_we              (cfg_we),
    .cfg_vertex_count    (cfg_vertex_count),
    .out_valid           (out_valid),
    .out_component_count (out_component_count),
    .out_distinct_edges  (out_distinct_edges)
  );

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: self-checking testbench for graph_component_counter
// depends on gcc_pkg and the graph_component_counter rtl; drives edge and count
// items, predicts every count result and checks it as it leaves the block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles of quiet before a vertex count write, and the tail after the last result
  localparam int WRITE_QUIET  = 4;
  localparam int TAIL_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1750;

  typedef enum logic [1:0] {
    PLAN_ITEM,    // one item for the input channel
    PLAN_VCOUNT,  // vertex count write, only while the block is idle
    PLAN_DRAIN    // sender holds off until every count result is back
  } plan_kind_t;

  typedef struct {
    plan_kind_t                    kind;
    logic                          op;
    logic [gcc_pkg::VIDX_W-1:0]    a;
    logic [gcc_pkg::VIDX_W-1:0]    b;
    logic [gcc_pkg::VCFG_W-1:0]    vcount;
  } plan_entry_t;

  typedef struct {
    logic [gcc_pkg::COMP_W-1:0]  comps;
    logic [gcc_pkg::TALLY_W-1:0] edges;
  } count_result_t;

  logic                          clk;
  logic                          rst_n            = 1'b0;
  logic                          start            = 1'b0;
  logic                          busy;
  logic                          in_opcode        = gcc_pkg::OP_INSERT;
  logic [gcc_pkg::VIDX_W-1:0]    in_vertex_a      = '0;
  logic [gcc_pkg::VIDX_W-1:0]    in_vertex_b      = '0;
  logic                          out_valid;
  logic [gcc_pkg::COMP_W-1:0]    out_component_count;
  logic [gcc_pkg::TALLY_W-1:0]   out_distinct_edges;
  logic                          cfg_we           = 1'b0;
  logic [gcc_pkg::VCFG_W-1:0]    cfg_vertex_count = gcc_pkg::VCOUNT_RESET;

  // stimulus waiting to be driven, and count results still owed by the block
  plan_entry_t   item_plan[$];
  count_result_t owed_counts[$];

  // graph model: adjacency rows, distinct edge tally and vertex count
  logic [gcc_pkg::MAX_VERTICES-1:0] model_rows [gcc_pkg::MAX_VERTICES];
  logic [gcc_pkg::TALLY_W-1:0]      model_tally  = '0;
  logic [gcc_pkg::VCFG_W-1:0]       model_vcount = gcc_pkg::VCOUNT_RESET;

  // vertex count as the plan builder sees it, to aim endpoints in range
  int plan_vertices = gcc_pkg::MAX_VERTICES;

  int items_sent     = 0;
  int counts_checked = 0;
  int vcount_writes  = 0;
  int mismatches     = 0;

  // sender burst shaping
  int burst_left   = 1;
  int gap_left     = 0;
  int quiet_cycles = 0;

  graph_component_counter i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_vertex_a         (in_vertex_a),
    .in_vertex_b         (in_vertex_b),
    .out_valid           (out_valid),
    .out_component_count (out_component_count),
    .out_distinct_edges  (out_distinct_edges),
    .cfg_we              (cfg_we),
    .cfg_vertex_count    (cfg_vertex_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (model_rows[i]) model_rows[i] = '0;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // counts above 64 saturate, zero leaves no vertices at all
  function automatic int model_vertices();
    return (model_vcount > gcc_pkg::MAX_VERTICES) ? gcc_pkg::MAX_VERTICES
                                                   : int'(model_vcount);
  endfunction

  // new in-range edge sets both mirrored bits and bumps the tally once
  function automatic void store_edge(logic [gcc_pkg::VIDX_W-1:0] a,
                                     logic [gcc_pkg::VIDX_W-1:0] b);
    int n;
    n = model_vertices();
    if (a < n && b < n && !model_rows[a][b]) begin
      model_rows[a][b] = 1'b1;
      model_rows[b][a] = 1'b1;
      if (model_tally != gcc_pkg::TALLY_MAX) model_tally++;
    end
  endfunction

  // grow each component from its lowest unvisited vertex until it stops growing;
  // neighbors at or above the current vertex count are not followed
  function automatic logic [gcc_pkg::COMP_W-1:0] count_components();
    logic [gcc_pkg::MAX_VERTICES-1:0] in_range;
    logic [gcc_pkg::MAX_VERTICES-1:0] seen;
    logic [gcc_pkg::MAX_VERTICES-1:0] reach;
    logic [gcc_pkg::MAX_VERTICES-1:0] grown;
    int n;
    int comps;
    n = model_vertices();
    in_range = (n >= gcc_pkg::MAX_VERTICES) ? '1 : ((64'd1 << n) - 64'd1);
    seen = '0;
    comps = 0;
    for (int s = 0; s < n; s++) begin
      if (!seen[s]) begin
        if (comps < int'(gcc_pkg::COMP_MAX)) comps++;
        reach = 64'd1 << s;
        grown = '0;
        while (grown != reach) begin
          grown = reach;
          for (int v = 0; v < gcc_pkg::MAX_VERTICES; v++)
            if (grown[v]) reach |= model_rows[v] & in_range;
        end
        seen |= reach;
      end
    end
    return gcc_pkg::COMP_W'(comps);
  endfunction

  // a count owes one result and then drops the graph
  function automatic void predict_item(logic op, logic [gcc_pkg::VIDX_W-1:0] a,
                                       logic [gcc_pkg::VIDX_W-1:0] b);
    count_result_t want;
    if (op == gcc_pkg::OP_INSERT) begin
      store_edge(a, b);
    end else begin
      want.comps = count_components();
      want.edges = model_tally;
      owed_counts.push_back(want);
      foreach (model_rows[i]) model_rows[i] = '0;
      model_tally = '0;
    end
  endfunction

  task automatic plan_item(logic op, logic [gcc_pkg::VIDX_W-1:0] a,
                           logic [gcc_pkg::VIDX_W-1:0] b);
    plan_entry_t e;
    e.kind = PLAN_ITEM;
    e.op = op;
    e.a = a;
    e.b = b;
    e.vcount = '0;
    item_plan.push_back(e);
  endtask

  task automatic plan_vcount(logic [gcc_pkg::VCFG_W-1:0] v);
    plan_entry_t e;
    e.kind = PLAN_VCOUNT;
    e.op = gcc_pkg::OP_INSERT;
    e.a = '0;
    e.b = '0;
    e.vcount = v;
    item_plan.push_back(e);
    plan_vertices = (v > gcc_pkg::MAX_VERTICES) ? gcc_pkg::MAX_VERTICES : int'(v);
  endtask

  task automatic plan_drain();
    plan_entry_t e;
    e.kind = PLAN_DRAIN;
    e.op = gcc_pkg::OP_INSERT;
    e.a = '0;
    e.b = '0;
    e.vcount = '0;
    item_plan.push_back(e);
  endtask

  // driver: presents planned items in bursts, holds an item until busy is low,
  // and writes the vertex count only once the block has gone quiet
  always @(posedge clk) begin : item_driver
    logic        next_start;
    logic        next_we;
    bit          taken;
    plan_entry_t head;
    next_start = start;
    next_we    = 1'b0;
    taken      = 1'b0;
    if (!rst_n) begin
      next_start   = 1'b0;
      quiet_cycles = 0;
    end else begin
      taken = (start && !busy);
      if (!start && !busy) quiet_cycles++;
      else quiet_cycles = 0;

      // the item on the ports is taken at this edge
      if (taken) begin
        predict_item(in_opcode, in_vertex_a, in_vertex_b);
        items_sent++;
        next_start = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end

      // an item still waiting on busy stays as it is
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (item_plan.size() > 0) begin
          head = item_plan[0];
          case (head.kind)
            PLAN_ITEM: begin
              head = item_plan.pop_front();
              in_opcode   <= head.op;
              in_vertex_a <= head.a;
              in_vertex_b <= head.b;
              next_start  = 1'b1;
            end
            default: begin
              // inserts leave no result behind, so wait out a few quiet cycles
              if (!taken && quiet_cycles >= WRITE_QUIET && owed_counts.size() == 0) begin
                head = item_plan.pop_front();
                if (head.kind == PLAN_VCOUNT) begin
                  next_we          = 1'b1;
                  cfg_vertex_count <= head.vcount;
                  model_vcount     = head.vcount;
                  vcount_writes++;
                end
              end
            end
          endcase
        end
      end
    end
    start  <= next_start;
    cfg_we <= next_we;
  end

  // monitor: every strobed result must match the oldest owed count
  always @(posedge clk) begin : count_monitor
    count_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (owed_counts.size() == 0) begin
        report_mismatch($sformatf("result with none owed: components %0d edges %0d",
                                  out_component_count, out_distinct_edges));
      end else begin
        want = owed_counts.pop_front();
        counts_checked++;
        if (out_component_count !== want.comps)
          report_mismatch($sformatf("component count %0d, want %0d",
                                    out_component_count, want.comps));
        if (out_distinct_edges !== want.edges)
          report_mismatch($sformatf("distinct edges %0d, want %0d",
                                    out_distinct_edges, want.edges));
      end
    end
  end

  // plan the whole run, release reset, then wait for the block to drain
  initial begin : stimulus
    int                          drawn;
    int                          graph_len;
    int                          roll;
    logic [gcc_pkg::VIDX_W-1:0]  a;
    logic [gcc_pkg::VIDX_W-1:0]  b;
    logic [gcc_pkg::VIDX_W-1:0]  last_a;
    logic [gcc_pkg::VIDX_W-1:0]  last_b;
    logic [gcc_pkg::VCFG_W-1:0]  v;

    // empty graph at the reset vertex count
    plan_item(gcc_pkg::OP_COUNT, 6'd0, 6'd0);
    // corner endpoints, a repeated edge in reverse, self loops, a short chain
    plan_item(gcc_pkg::OP_INSERT, 6'd0, 6'd63);
    plan_item(gcc_pkg::OP_INSERT, 6'd63, 6'd0);
    plan_item(gcc_pkg::OP_INSERT, 6'd5, 6'd5);
    plan_item(gcc_pkg::OP_INSERT, 6'd63, 6'd63);
    plan_item(gcc_pkg::OP_INSERT, 6'd0, 6'd1);
    plan_item(gcc_pkg::OP_INSERT, 6'd1, 6'd2);
    plan_item(gcc_pkg::OP_COUNT, 6'd63, 6'd63);
    // largest register value saturates at the vertex limit
    plan_vcount(7'd127);
    plan_item(gcc_pkg::OP_INSERT, 6'd63, 6'd62);
    plan_item(gcc_pkg::OP_COUNT, 6'd42, 6'd21);
    // no vertices: inserts ignored, zero components
    plan_vcount(7'd0);
    plan_item(gcc_pkg::OP_INSERT, 6'd0, 6'd0);
    plan_item(gcc_pkg::OP_COUNT, 6'd0, 6'd0);
    // single vertex: self loop kept, other endpoint out of range
    plan_vcount(7'd1);
    plan_item(gcc_pkg::OP_INSERT, 6'd0, 6'd0);
    plan_item(gcc_pkg::OP_INSERT, 6'd0, 6'd1);
    plan_item(gcc_pkg::OP_COUNT, 6'd21, 6'd42);
    plan_vcount(7'd2);
    plan_item(gcc_pkg::OP_INSERT, 6'd1, 6'd0);
    plan_item(gcc_pkg::OP_COUNT, 6'd0, 6'd0);
    plan_drain();
    // vertex count lowered mid-build: old edges stay, high neighbors unreachable
    plan_vcount(7'd64);
    plan_item(gcc_pkg::OP_INSERT, 6'd0, 6'd1);
    plan_item(gcc_pkg::OP_INSERT, 6'd10, 6'd40);
    plan_vcount(7'd20);
    plan_item(gcc_pkg::OP_INSERT, 6'd40, 6'd3);
    plan_item(gcc_pkg::OP_INSERT, 6'd3, 6'd19);
    plan_item(gcc_pkg::OP_COUNT, 6'd0, 6'd0);

    // random graphs: mostly in-range edges, with repeats, strays and retunes
    drawn  = 0;
    last_a = '0;
    last_b = '0;
    while (drawn < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        roll = $urandom_range(0, 9);
        case (roll)
          0:       v = 7'd0;
          1:       v = 7'd1;
          2:       v = 7'd2;
          3, 4:    v = 7'd64;
          5:       v = gcc_pkg::VCFG_W'($urandom_range(65, 127));
          default: v = gcc_pkg::VCFG_W'($urandom_range(3, 63));
        endcase
        plan_vcount(v);
      end
      // most graphs stay short; a few run much longer and denser
      graph_len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(0, 24);
      for (int k = 0; k < graph_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 70 && plan_vertices > 0) begin
          a = gcc_pkg::VIDX_W'($urandom_range(0, plan_vertices - 1));
          b = gcc_pkg::VIDX_W'($urandom_range(0, plan_vertices - 1));
        end else if (roll < 82) begin
          // same edge again, either way round
          a = ($urandom_range(0, 1) == 0) ? last_a : last_b;
          b = (a == last_a) ? last_b : last_a;
        end else if (roll < 93 || plan_vertices == 0) begin
          a = gcc_pkg::VIDX_W'($urandom_range(0, 63));
          b = gcc_pkg::VIDX_W'($urandom_range(0, 63));
        end else if (roll < 96) begin
          a = gcc_pkg::VIDX_W'($urandom_range(0, plan_vertices - 1));
          b = a;
        end else if (roll < 98) begin
          plan_vcount(gcc_pkg::VCFG_W'($urandom_range(1, 64)));
          continue;
        end else begin
          plan_drain();
          continue;
        end
        plan_item(gcc_pkg::OP_INSERT, a, b);
        last_a = a;
        last_b = b;
        drawn++;
      end
      plan_item(gcc_pkg::OP_COUNT, gcc_pkg::VIDX_W'($urandom_range(0, 63)),
                gcc_pkg::VIDX_W'($urandom_range(0, 63)));
      drawn++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // everything driven and every owed count returned
    while (item_plan.size() != 0 || start || owed_counts.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items with %0d count results checked across %0d vertex count writes",
             items_sent, counts_checked, vcount_writes);
    $display("mismatches seen: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin : watchdog
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
